// ===== hdl/sll_pkg.sv =====
// shared types and constants for the static linked list engine
// no dependencies; imported by sll_ctrl and static_linked_list_engine
`timescale 1ns / 1ps

package sll_pkg;

    localparam int POS_W   = 10;   // request position width
    localparam int VAL_W   = 32;   // element data width
    localparam int OUT_W   = 10;   // slot and length field width

    localparam int S_DATA_W = 48;  // position + value, padded to bytes
    localparam int M_DATA_W = 24;  // slot + length, padded to bytes

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef struct packed {
        logic               command;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   value;
    } sll_cmd_t;

    typedef struct packed {
        logic [OUT_W-1:0]   slot;
        logic [OUT_W-1:0]   length;
    } sll_result_t;

endpackage

// ===== hdl/sll_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies; read returns the old contents on a same-address write
`timescale 1ns / 1ps

module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sll_ctrl.sv =====
// sequencer for the linked list: clearing sweep, link walk, splice and unlink
// depends on sll_pkg and sll_ram (link store and element data store)
`timescale 1ns / 1ps

module sll_ctrl
    import sll_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  sll_cmd_t    cmd,
    output logic        res_valid,
    input  logic        res_take,
    output sll_result_t res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ((AW > POS_W) ? AW : POS_W) + 1;

    localparam logic [AW-1:0] FREE_HEAD = '0;
    localparam logic [AW-1:0] LIST_HEAD = AW'(DEPTH - 1);
    localparam logic [AW-1:0] LAST_FREE = AW'(DEPTH - 2);

    localparam logic [3:0] ST_CLEAR      = 4'd0;
    localparam logic [3:0] ST_IDLE       = 4'd1;
    localparam logic [3:0] ST_INS_FREE   = 4'd2;
    localparam logic [3:0] ST_INS_POP    = 4'd3;
    localparam logic [3:0] ST_WALK       = 4'd4;
    localparam logic [3:0] ST_INS_LINK   = 4'd5;
    localparam logic [3:0] ST_DEL_UNLINK = 4'd6;
    localparam logic [3:0] ST_DEL_FREE   = 4'd7;
    localparam logic [3:0] ST_DEL_PUSH   = 4'd8;
    localparam logic [3:0] ST_FIN        = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [AW-1:0]    count_reg, count_next;
    logic [AW-1:0]    node_reg, node_next;
    logic [AW-1:0]    remain_reg, remain_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [AW-1:0]    k_reg, k_next;
    logic             del_reg, del_next;
    logic [VAL_W-1:0] val_reg, val_next;
    sll_result_t      res_reg, res_next;

    logic             lk_we;
    logic [AW-1:0]    lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic             dt_we;

    logic [CW-1:0]    pos_w, cnt_w, pos_m1;
    logic             ins_ok, del_ok;

    function automatic logic [OUT_W-1:0] to_out(input logic [AW-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return w[OUT_W-1:0];
    endfunction

    assign pos_w  = CW'(cmd.position);
    assign cnt_w  = CW'(count_reg);
    assign pos_m1 = pos_w - CW'(1);
    assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + CW'(1));
    assign del_ok = (pos_w != '0) && (pos_w <= cnt_w);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        node_next   = node_reg;
        remain_next = remain_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        del_next    = del_reg;
        val_next    = val_reg;
        res_next    = res_reg;
        lk_we       = 1'b0;
        lk_waddr    = j_reg;
        lk_wdata    = lk_rdata;
        lk_raddr    = LIST_HEAD;
        dt_we       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // free chain 1..DEPTH-2, both heads end at zero
                lk_we    = 1'b1;
                lk_waddr = clr_reg;
                lk_wdata = (clr_reg < LAST_FREE) ? clr_reg + AW'(1) : '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LIST_HEAD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    del_next    = (cmd.command == CMD_DELETE);
                    val_next    = cmd.value;
                    remain_next = pos_m1[AW-1:0];
                    node_next   = LIST_HEAD;
                    res_next    = '{slot: '0, length: to_out(count_reg)};
                    if (cmd.command == CMD_INSERT)
                    begin
                        lk_raddr   = FREE_HEAD;
                        state_next = ins_ok ? ST_INS_FREE : ST_FIN;
                    end
                    else
                    begin
                        lk_raddr   = LIST_HEAD;
                        state_next = del_ok ? ST_WALK : ST_FIN;
                    end
                end
            end
            ST_INS_FREE:
            begin
                // first free slot, zero means the pool is empty
                if (lk_rdata == '0 || lk_rdata == LIST_HEAD)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    j_next     = lk_rdata;
                    lk_raddr   = lk_rdata;
                    state_next = ST_INS_POP;
                end
            end
            ST_INS_POP:
            begin
                lk_we      = 1'b1;
                lk_waddr   = FREE_HEAD;
                lk_wdata   = lk_rdata;
                dt_we      = 1'b1;
                lk_raddr   = LIST_HEAD;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // lk_rdata holds the link of node_reg
                if (remain_reg == '0)
                begin
                    k_next = node_reg;
                    if (!del_reg)
                    begin
                        lk_we      = 1'b1;
                        lk_waddr   = j_reg;
                        lk_wdata   = lk_rdata;
                        state_next = ST_INS_LINK;
                    end
                    else if (lk_rdata == '0 || lk_rdata == LIST_HEAD)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        j_next     = lk_rdata;
                        lk_raddr   = lk_rdata;
                        state_next = ST_DEL_UNLINK;
                    end
                end
                else
                begin
                    node_next   = lk_rdata;
                    lk_raddr    = lk_rdata;
                    remain_next = remain_reg - AW'(1);
                end
            end
            ST_INS_LINK:
            begin
                lk_we      = 1'b1;
                lk_waddr   = k_reg;
                lk_wdata   = j_reg;
                count_next = count_reg + AW'(1);
                res_next   = '{slot: to_out(j_reg), length: to_out(count_reg + AW'(1))};
                state_next = ST_FIN;
            end
            ST_DEL_UNLINK:
            begin
                lk_we      = 1'b1;
                lk_waddr   = k_reg;
                lk_wdata   = lk_rdata;
                lk_raddr   = FREE_HEAD;
                state_next = ST_DEL_FREE;
            end
            ST_DEL_FREE:
            begin
                lk_we      = 1'b1;
                lk_waddr   = j_reg;
                lk_wdata   = lk_rdata;
                state_next = ST_DEL_PUSH;
            end
            ST_DEL_PUSH:
            begin
                lk_we      = 1'b1;
                lk_waddr   = FREE_HEAD;
                lk_wdata   = j_reg;
                count_next = count_reg - AW'(1);
                res_next   = '{slot: to_out(j_reg), length: to_out(count_reg - AW'(1))};
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        remain_reg <= remain_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        del_reg    <= del_next;
        val_reg    <= val_next;
        res_reg    <= res_next;
    end

    sll_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    // element data is stored for each inserted slot, never read back
    sll_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (dt_we),
        .waddr (j_reg),
        .wdata (val_reg),
        .raddr (j_reg),
        .rdata ()
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN);
    assign res       = res_reg;

    // the element count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + AW'(1) ||
             count_reg == $past(count_reg) - AW'(1)))
        else $error("element count jumped");

    // the list never holds more than the usable slots
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_FREE)
        else $error("element count beyond capacity");

    // a nonzero link never points back at its own slot
    a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
        (lk_we && lk_wdata != '0) |-> (lk_waddr != lk_wdata))
        else $error("self link written");

    // a granted slot is never one of the chain heads
    a_slot_not_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_LINK || state_reg == ST_DEL_PUSH) |->
            (j_reg != FREE_HEAD && j_reg != LIST_HEAD))
        else $error("head slot used as element");

endmodule

// ===== hdl/static_linked_list_engine.sv =====
// static linked list engine: a request rejected on its position skips the link walk
// and returns slot zero, as does an insert refused for lack of a free slot; the link
// walk reads one link per cycle from the link ram. one request at a time; the next
// request is taken once the previous result is in the output register. after reset
// a clearing sweep builds the free chain; s_tready stays low until it ends
`timescale 1ns / 1ps

module static_linked_list_engine
    import sll_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [9:0] position, [41:10] value, rest zero
    input  logic                s_tuser,   // [0] command: 0 insert, 1 delete
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [9:0] slot, [19:10] length, rest zero
);

    sll_cmd_t    cmd;
    sll_result_t res;
    logic        res_valid;
    logic        res_take;

    logic              m_tvalid_reg, m_tvalid_next;
    sll_result_t       out_reg;

    // unpack the request fields, lowest field first
    assign cmd.command  = s_tuser;
    assign cmd.position = s_tdata[POS_W-1:0];
    assign cmd.value    = s_tdata[POS_W+VAL_W-1:POS_W];

    sll_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // output register loads when empty or being drained this cycle
    assign res_take = res_valid && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (res_take)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W-2*OUT_W){1'b0}}, out_reg.length, out_reg.slot};

endmodule
